@@ sv/bdeq_pkg.sv @@
`timescale 1ns / 1ps

package bdeq_pkg;

   localparam int TIME_BITS      = 32;
   localparam int CFG_BITS       = 16;
   localparam int CODE_BITS      = 5;
   localparam int SINGLE_BUTTONS = 3;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_MS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_HOLD_MS   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRE_ON_PRESS = 2'd2;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_MS_RESET   = 16'd50;
   localparam logic [CFG_BITS-1:0] MIN_HOLD_MS_RESET   = 16'd0;
   localparam logic                FIRE_ON_PRESS_RESET = 1'b1;

   typedef struct packed {
      logic [TIME_BITS-1:0] now_ms;
      logic                 power_level;
      logic                 clock_ok_level;
      logic                 clock_set_level;
      logic [CODE_BITS-1:0] matrix_code;
   } req_type;

   typedef struct packed {
      logic                 power_event;
      logic                 clock_ok_event;
      logic                 clock_set_event;
      logic                 code_event;
      logic [CODE_BITS-1:0] event_code;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] min_hold_ms;
      logic                fire_on_press;
   } cfg_type;

endpackage

@@ sv/button_debounce_event_qualifier.sv @@
`timescale 1ns / 1ps

// Debounces three single buttons and one multiplexed button code from a stream of
// timestamped polls and returns one event word per poll. Each button runs in its
// own lane, one subtract and two compares wide, so a poll is taken every cycle while
// req_stall is low, and its event word is registered in the output stage. A two-entry
// output stage (output register plus skid register) lets a new poll enter while a word
// waits. Configuration writes are taken without a stall and must be done while idle.
module button_debounce_event_qualifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bdeq_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bdeq_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdeq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdeq_pkg::CFG_BITS-1:0]       csr_data
);

   bdeq_pkg::cfg_type                    cfg_ff, cfg_in;
   logic                                 accept;
   logic [bdeq_pkg::SINGLE_BUTTONS-1:0]  single_level;
   logic [bdeq_pkg::SINGLE_BUTTONS-1:0]  single_fire;
   logic                                 code_fire;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bdeq_pkg::CSR_DEBOUNCE_MS:   cfg_in.debounce_ms   = csr_data;
            bdeq_pkg::CSR_MIN_HOLD_MS:   cfg_in.min_hold_ms   = csr_data;
            bdeq_pkg::CSR_FIRE_ON_PRESS: cfg_in.fire_on_press = csr_data[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= bdeq_pkg::DEBOUNCE_MS_RESET;
         cfg_ff.min_hold_ms   <= bdeq_pkg::MIN_HOLD_MS_RESET;
         cfg_ff.fire_on_press <= bdeq_pkg::FIRE_ON_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign single_level = {req_data.clock_set_level, req_data.clock_ok_level,
                          req_data.power_level};

   for (genvar i = 0; i < bdeq_pkg::SINGLE_BUTTONS; i++) begin : g_single
      bdeq_lane #(
         .LEVEL_BITS (1)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .accept  (accept),
         .now_ms  (req_data.now_ms),
         .level   (single_level[i]),
         .qualify (single_level[i] == cfg_ff.fire_on_press),
         .cfg     (cfg_ff),
         .fire    (single_fire[i])
      );
   end

   bdeq_lane #(
      .LEVEL_BITS (bdeq_pkg::CODE_BITS)
   ) u_code_lane (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .now_ms  (req_data.now_ms),
      .level   (req_data.matrix_code),
      .qualify (|req_data.matrix_code),
      .cfg     (cfg_ff),
      .fire    (code_fire)
   );

   bdeq_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .single_fire (single_fire),
      .code_fire   (code_fire),
      .code        (req_data.matrix_code),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

@@ sv/bdeq_lane.sv @@
`timescale 1ns / 1ps

module bdeq_lane #(
   parameter int LEVEL_BITS = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [bdeq_pkg::TIME_BITS-1:0]     now_ms,
   input  logic [LEVEL_BITS-1:0]              level,
   input  logic                               qualify,
   input  bdeq_pkg::cfg_type                  cfg,
   output logic                               fire
);

   logic [LEVEL_BITS-1:0]            level_ff, level_in;
   logic [bdeq_pkg::TIME_BITS-1:0]   stamp_ff, stamp_in;
   logic                             fired_ff, fired_in;
   logic [bdeq_pkg::TIME_BITS-1:0]   elapsed;
   logic [bdeq_pkg::TIME_BITS-1:0]   hold_elapsed;
   logic                             change;

   // A change that is taken restamps the lane, so its hold time starts at zero.
   always_comb begin
      elapsed      = now_ms - stamp_ff;
      change       = (level != level_ff) &&
                     (elapsed >= {{(bdeq_pkg::TIME_BITS-bdeq_pkg::CFG_BITS){1'b0}},
                                  cfg.debounce_ms});
      hold_elapsed = change ? '0 : elapsed;
      fire         = (change || !fired_ff) && qualify &&
                     (hold_elapsed >= {{(bdeq_pkg::TIME_BITS-bdeq_pkg::CFG_BITS){1'b0}},
                                       cfg.min_hold_ms});
      level_in     = level_ff;
      stamp_in     = stamp_ff;
      fired_in     = fired_ff;
      if (accept) begin
         if (change) begin
            level_in = level;
            stamp_in = now_ms;
            fired_in = 1'b0;
         end
         if (fire) begin
            fired_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         stamp_ff <= '0;
         fired_ff <= 1'b1;
      end else begin
         level_ff <= level_in;
         stamp_ff <= stamp_in;
         fired_ff <= fired_in;
      end
   end

endmodule

@@ sv/bdeq_merge.sv @@
`timescale 1ns / 1ps

module bdeq_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [bdeq_pkg::SINGLE_BUTTONS-1:0]  single_fire,
   input  logic                                 code_fire,
   input  logic [bdeq_pkg::CODE_BITS-1:0]       code,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bdeq_pkg::rsp_type                    rsp_data
);

   bdeq_pkg::rsp_type event_word;
   bdeq_pkg::rsp_type out_ff, out_in;
   bdeq_pkg::rsp_type skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              drain;

   always_comb begin
      event_word.power_event     = single_fire[0];
      event_word.clock_ok_event  = single_fire[1];
      event_word.clock_set_event = single_fire[2];
      event_word.code_event      = code_fire;
      event_word.event_code      = code_fire ? code : '0;
   end

   // The skid stage catches a word that arrives while the output word is stalled.
   always_comb begin
      drain         = !out_valid_ff || !rsp_stall;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in        = event_word;
            out_valid_in  = accept;
         end
      end else if (accept) begin
         skid_in       = event_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid word held without an output word.");

   a_skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall && accept))
      else $error("Skid stage filled without a stalled output.");

   a_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.code_event) |-> (out_ff.event_code != '0))
      else $error("Code event with a zero code.");

   a_code_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.code_event) |-> (out_ff.event_code == '0))
      else $error("Event code set without a code event.");

endmodule

@@ dv/button_debounce_event_qualifier_tb.sv @@
`timescale 1ns / 1ps

module button_debounce_event_qualifier_tb;

   typedef logic [bdeq_pkg::CODE_BITS-1:0] code_type;
   typedef logic [bdeq_pkg::CFG_BITS-1:0]  cfg_word_type;

   localparam logic [bdeq_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES = 8;
   localparam int PHASE_POLLS = 270;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bdeq_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bdeq_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bdeq_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [bdeq_pkg::CFG_BITS-1:0] csr_data = '0;

   button_debounce_event_qualifier uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [bdeq_pkg::CFG_BITS-1:0] debounce_ms_q = bdeq_pkg::DEBOUNCE_MS_RESET;
   logic [bdeq_pkg::CFG_BITS-1:0] hold_ms_q = bdeq_pkg::MIN_HOLD_MS_RESET;
   logic fire_on_press_q = bdeq_pkg::FIRE_ON_PRESS_RESET;
   logic btn_level [bdeq_pkg::SINGLE_BUTTONS];
   logic [bdeq_pkg::TIME_BITS-1:0] btn_stamp [bdeq_pkg::SINGLE_BUTTONS];
   logic btn_fired [bdeq_pkg::SINGLE_BUTTONS];
   logic [bdeq_pkg::CODE_BITS-1:0] code_accepted;
   logic [bdeq_pkg::TIME_BITS-1:0] code_stamp;
   logic code_fired;

   bdeq_pkg::rsp_type pending_events [$];
   int fail_count = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;

   // Debounce acceptance is applied first, so the hold check sees the fresh stamp.
   function automatic bdeq_pkg::rsp_type qualify_poll(input bdeq_pkg::req_type poll);
      bdeq_pkg::rsp_type word;
      logic [bdeq_pkg::SINGLE_BUTTONS-1:0] levels;
      logic [bdeq_pkg::SINGLE_BUTTONS-1:0] fired_now;
      logic [bdeq_pkg::TIME_BITS-1:0] elapsed;
      int i;
      word = '0;
      fired_now = '0;
      levels = {poll.clock_set_level, poll.clock_ok_level, poll.power_level};
      for (i = 0; i < bdeq_pkg::SINGLE_BUTTONS; i++) begin
         elapsed = poll.now_ms - btn_stamp[i];
         if (levels[i] != btn_level[i] && elapsed >= {16'd0, debounce_ms_q}) begin
            btn_level[i] = levels[i];
            btn_stamp[i] = poll.now_ms;
            btn_fired[i] = 1'b0;
         end
         elapsed = poll.now_ms - btn_stamp[i];
         if (!btn_fired[i] && levels[i] == fire_on_press_q &&
             elapsed >= {16'd0, hold_ms_q}) begin
            btn_fired[i] = 1'b1;
            fired_now[i] = 1'b1;
         end
      end
      word.power_event = fired_now[0];
      word.clock_ok_event = fired_now[1];
      word.clock_set_event = fired_now[2];
      elapsed = poll.now_ms - code_stamp;
      if (poll.matrix_code != code_accepted && elapsed >= {16'd0, debounce_ms_q}) begin
         code_accepted = poll.matrix_code;
         code_stamp = poll.now_ms;
         code_fired = 1'b0;
      end
      elapsed = poll.now_ms - code_stamp;
      if (!code_fired && poll.matrix_code != '0 && elapsed >= {16'd0, hold_ms_q}) begin
         code_fired = 1'b1;
         word.code_event = 1'b1;
         word.event_code = poll.matrix_code;
      end
      return word;
   endfunction

   function automatic bdeq_pkg::req_type make_poll(
         input logic [bdeq_pkg::TIME_BITS-1:0] now_ms, input logic power,
         input logic clock_ok, input logic clock_set,
         input logic [bdeq_pkg::CODE_BITS-1:0] code);
      bdeq_pkg::req_type poll;
      poll.now_ms = now_ms;
      poll.power_level = power;
      poll.clock_ok_level = clock_ok;
      poll.clock_set_level = clock_set;
      poll.matrix_code = code;
      return poll;
   endfunction

   task automatic send_poll(input bdeq_pkg::req_type poll);
      while (!no_gaps && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= poll;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_events.push_back(qualify_poll(poll));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bdeq_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [bdeq_pkg::CFG_BITS-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         bdeq_pkg::CSR_DEBOUNCE_MS: debounce_ms_q = value;
         bdeq_pkg::CSR_MIN_HOLD_MS: hold_ms_q = value;
         bdeq_pkg::CSR_FIRE_ON_PRESS: fire_on_press_q = value[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [bdeq_pkg::CFG_BITS-1:0] debounce,
                             input logic [bdeq_pkg::CFG_BITS-1:0] hold,
                             input logic [bdeq_pkg::CFG_BITS-1:0] press);
      write_csr(bdeq_pkg::CSR_DEBOUNCE_MS, debounce);
      write_csr(bdeq_pkg::CSR_MIN_HOLD_MS, hold);
      write_csr(bdeq_pkg::CSR_FIRE_ON_PRESS, press);
   endtask

   task automatic check_field(input string name, input logic [bdeq_pkg::CODE_BITS-1:0] want,
                              input logic [bdeq_pkg::CODE_BITS-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      bdeq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            fail_count++;
            $display("%0t event word %h arrived with none expected", $time, rsp_data);
         end else begin
            want = pending_events.pop_front();
            check_field("power_event", code_type'(want.power_event),
                        code_type'(rsp_data.power_event));
            check_field("clock_ok_event", code_type'(want.clock_ok_event),
                        code_type'(rsp_data.clock_ok_event));
            check_field("clock_set_event", code_type'(want.clock_set_event),
                        code_type'(rsp_data.clock_set_event));
            check_field("code_event", code_type'(want.code_event),
                        code_type'(rsp_data.code_event));
            check_field("event_code", want.event_code, rsp_data.event_code);
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(99) < 30);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t no handshake for %0d cycles", $time, idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_defaults_and_wrap();
      send_poll(make_poll(32'd0, 1'b1, 1'b1, 1'b1, 5'd31));
      send_poll(make_poll(32'd49, 1'b1, 1'b1, 1'b1, 5'd31));
      send_poll(make_poll(32'd50, 1'b1, 1'b1, 1'b1, 5'd31));
      send_poll(make_poll(32'd60, 1'b0, 1'b0, 1'b0, 5'd0));
      send_poll(make_poll(32'd100, 1'b0, 1'b0, 1'b0, 5'd0));
      send_poll(make_poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 5'd1));
      send_poll(make_poll(32'h0000_0031, 1'b0, 1'b0, 1'b0, 5'd0));
   endtask

   task automatic test_release_mode();
      write_csr(CSR_UNUSED, 16'hFFFF);
      write_csr(bdeq_pkg::CSR_DEBOUNCE_MS, 16'd0);
      write_csr(bdeq_pkg::CSR_MIN_HOLD_MS, 16'd20);
      write_csr(bdeq_pkg::CSR_FIRE_ON_PRESS, 16'hFFFE);
      send_poll(make_poll(32'h1000, 1'b1, 1'b1, 1'b1, 5'd5));
      send_poll(make_poll(32'h1014, 1'b1, 1'b1, 1'b1, 5'd5));
      send_poll(make_poll(32'h1015, 1'b0, 1'b0, 1'b0, 5'd0));
      send_poll(make_poll(32'h1029, 1'b0, 1'b0, 1'b0, 5'd0));
   endtask

   task automatic test_extreme_settings();
      set_config(16'hFFFF, 16'hFFFF, 16'd1);
      send_poll(make_poll(32'h2000, 1'b1, 1'b1, 1'b1, 5'd31));
      send_poll(make_poll(32'h1_1014, 1'b1, 1'b1, 1'b1, 5'd31));
      send_poll(make_poll(32'h2_1012, 1'b1, 1'b1, 1'b1, 5'd31));
      send_poll(make_poll(32'h2_1013, 1'b1, 1'b1, 1'b1, 5'd31));
      set_config(16'd0, 16'd0, 16'd1);
      send_poll(make_poll(32'h5555_5555, 1'b1, 1'b0, 1'b1, 5'd10));
      send_poll(make_poll(32'hAAAA_AAAA, 1'b0, 1'b1, 1'b0, 5'd21));
      send_poll(make_poll(32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1, 5'd0));
   endtask

   // Mostly steady time with occasional toggles, plus a share of arbitrary polls.
   task automatic run_random_phase(input logic [bdeq_pkg::TIME_BITS-1:0] start_ms,
                                   input bit pause_midway);
      logic [bdeq_pkg::TIME_BITS-1:0] wall_ms;
      logic [bdeq_pkg::SINGLE_BUTTONS-1:0] held;
      logic [bdeq_pkg::CODE_BITS-1:0] code;
      int unsigned span;
      int n;
      int b;
      wall_ms = start_ms;
      held = '0;
      code = '0;
      span = 2 * ((debounce_ms_q > hold_ms_q) ? int'(debounce_ms_q) : int'(hold_ms_q)) + 4;
      for (n = 0; n < PHASE_POLLS; n++) begin
         if (pause_midway && n == PHASE_POLLS / 2)
            wait_idle();
         if ($urandom_range(99) < 10) begin
            send_poll(make_poll($urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), code_type'($urandom_range(31))));
         end else begin
            wall_ms = wall_ms + $urandom_range(span, 0);
            for (b = 0; b < bdeq_pkg::SINGLE_BUTTONS; b++)
               if ($urandom_range(99) < 25)
                  held[b] = !held[b];
            if ($urandom_range(99) < 20)
               code = $urandom_range(1) ? '0 : code_type'($urandom_range(31));
            send_poll(make_poll(wall_ms, held[0], held[1], held[2], code));
         end
      end
   endtask

   task automatic test_random_phases();
      set_config(16'd50, 16'd0, 16'd1);
      run_random_phase(32'd0, 1'b1);
      set_config(16'd0, 16'd0, 16'd0);
      run_random_phase($urandom(), 1'b0);
      set_config(16'd10, 16'd30, 16'd1);
      no_gaps = 1'b1;
      run_random_phase($urandom(), 1'b0);
      no_gaps = 1'b0;
      set_config(16'hFFFF, 16'hFFFF, 16'd0);
      run_random_phase(32'hFFFF_0000, 1'b0);
      set_config(16'd3, 16'd3, 16'd1);
      run_random_phase($urandom(), 1'b0);
      set_config(cfg_word_type'($urandom_range(200)), cfg_word_type'($urandom_range(200)),
                 cfg_word_type'($urandom_range(1)));
      run_random_phase($urandom(), 1'b0);
      set_config(cfg_word_type'($urandom_range(200)), cfg_word_type'($urandom_range(200)),
                 cfg_word_type'($urandom_range(1)));
      run_random_phase($urandom(), 1'b0);
   endtask

   initial begin
      int i;
      for (i = 0; i < bdeq_pkg::SINGLE_BUTTONS; i++) begin
         btn_level[i] = 1'b0;
         btn_stamp[i] = '0;
         btn_fired[i] = 1'b1;
      end
      code_accepted = '0;
      code_stamp = '0;
      code_fired = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults_and_wrap();
      test_release_mode();
      test_extreme_settings();
      test_random_phases();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
